@@ design/i2cm_pkg.sv @@
// Shared types and constants for the I2C master transfer engine.
// No dependencies; imported by i2cm_core and i2c_master_transfer.
package i2cm_pkg;

  localparam int unsigned MAX_TRANSFER_BYTES = 255;
  localparam logic [15:0] HALF_PERIOD_RESET  = 16'd250;
  localparam logic [6:0]  MIN_ADDRESS        = 7'd7;
  localparam int unsigned BIT_COUNT_W        = 4;
  localparam logic [BIT_COUNT_W-1:0] BITS_PER_BYTE = 4'd8;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NACK    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_UNUSED  = 2'd3;

  typedef enum logic [15:0] {
    PH_IDLE        = 16'h0001,
    PH_START_SETUP = 16'h0002,
    PH_START_HOLD  = 16'h0004,
    PH_TX_LOW      = 16'h0008,
    PH_TX_HIGH     = 16'h0010,
    PH_TXACK_LOW   = 16'h0020,
    PH_TXACK_HIGH  = 16'h0040,
    PH_RX_LOW      = 16'h0080,
    PH_RX_HIGH     = 16'h0100,
    PH_RXACK_LOW   = 16'h0200,
    PH_RXACK_HIGH  = 16'h0400,
    PH_RS_LOW      = 16'h0800,
    PH_RS_HIGH     = 16'h1000,
    PH_STOP_LOW    = 16'h2000,
    PH_STOP_HIGH   = 16'h4000,
    PH_STOP_FREE   = 16'h8000
  } phase_t;

  // Phases that release SCL high; these wait while a slave stretches the clock.
  localparam logic [15:0] HIGH_PHASES = PH_START_SETUP | PH_TX_HIGH | PH_TXACK_HIGH |
                                        PH_RX_HIGH | PH_RXACK_HIGH | PH_RS_HIGH |
                                        PH_STOP_HIGH | PH_STOP_FREE;

  typedef struct packed {
    logic       start_req;
    logic [6:0] slave_addr;
    logic [7:0] write_count;
    logic [7:0] read_count;
    logic [7:0] write_data;
    logic       sda_in;
    logic       scl_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       byte_taken;
    logic       read_valid;
    logic [7:0] read_data;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

@@ design/i2cm_core.sv @@
// Bus sequencer of the I2C master: phase state machine, half-period timer and
// byte shifter. Advances one tick per step. Depends on i2cm_pkg.
module i2cm_core #(
  parameter int unsigned MaxTransferBytes = i2cm_pkg::MAX_TRANSFER_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [15:0]       half_period,
  input  i2cm_pkg::item_t   item,
  output i2cm_pkg::result_t result
);
  import i2cm_pkg::*;

  phase_t                 phase, phase_next;
  logic [15:0]            tick_count, tick_count_next;
  logic [BIT_COUNT_W-1:0] bit_count, bit_count_next;
  logic [7:0]             shift_byte, shift_byte_next;
  logic [6:0]             saved_address, saved_address_next;
  logic [7:0]             writes_left, writes_left_next;
  logic [7:0]             reads_left, reads_left_next;
  logic                   wrote_flag, wrote_flag_next;
  logic [1:0]             last_status, last_status_next;

  logic [15:0]            hp_eff;
  logic [16:0]            tick_inc;
  logic                   high_ph, stall, over;
  logic [BIT_COUNT_W-1:0] bit_inc;
  logic [7:0]             wsat, rsat;
  logic                   taken, rvalid, done, scl, sda;
  logic [7:0]             rdata;

  function automatic logic [7:0] sat_count(input logic [7:0] c);
    logic [15:0] lim;
    lim = 16'(MaxTransferBytes);
    return (16'(c) > lim) ? lim[7:0] : c;
  endfunction

  always_comb begin
    hp_eff   = (half_period == 16'd0) ? 16'd1 : half_period;
    high_ph  = |(phase & HIGH_PHASES);
    stall    = high_ph && !item.scl_in;
    tick_inc = {1'b0, tick_count} + 17'd1;
    over     = !stall && (tick_inc >= {1'b0, hp_eff});
    bit_inc  = bit_count + 1'b1;
    wsat     = sat_count(item.write_count);
    rsat     = sat_count(item.read_count);

    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    saved_address_next = saved_address;
    writes_left_next   = writes_left;
    reads_left_next    = reads_left;
    wrote_flag_next    = wrote_flag;
    last_status_next   = last_status;
    taken  = 1'b0;
    rvalid = 1'b0;
    rdata  = 8'd0;
    done   = 1'b0;

    // Timer runs in every bus phase; hold while SCL is stretched low.
    if (phase != PH_IDLE && !stall) begin
      tick_count_next = over ? 16'd0 : tick_inc[15:0];
    end

    unique case (phase)
      PH_IDLE: begin
        if (item.start_req) begin
          if (item.slave_addr < MIN_ADDRESS) begin
            last_status_next = ST_INVALID;
            done = 1'b1;
          end else begin
            saved_address_next = item.slave_addr;
            writes_left_next   = wsat;
            reads_left_next    = rsat;
            wrote_flag_next    = !(wsat == 8'd0 && rsat != 8'd0);
            tick_count_next    = 16'd0;
            bit_count_next     = '0;
            phase_next         = PH_START_SETUP;
          end
        end
      end
      PH_START_SETUP: if (over) phase_next = PH_START_HOLD;
      PH_START_HOLD: begin
        if (over) begin
          shift_byte_next = {saved_address, !wrote_flag};
          bit_count_next  = '0;
          phase_next      = PH_TX_LOW;
        end
      end
      PH_TX_LOW: if (over) phase_next = PH_TX_HIGH;
      PH_TX_HIGH: begin
        if (over) begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          if (bit_inc >= BITS_PER_BYTE) begin
            bit_count_next = '0;
            phase_next     = PH_TXACK_LOW;
          end else begin
            bit_count_next = bit_inc;
            phase_next     = PH_TX_LOW;
          end
        end
      end
      PH_TXACK_LOW: if (over) phase_next = PH_TXACK_HIGH;
      PH_TXACK_HIGH: begin
        if (over) begin
          if (item.sda_in) begin
            last_status_next = ST_NACK;
            phase_next       = PH_STOP_LOW;
          end else if (wrote_flag && writes_left != 8'd0) begin
            shift_byte_next  = item.write_data;
            taken            = 1'b1;
            writes_left_next = writes_left - 8'd1;
            bit_count_next   = '0;
            phase_next       = PH_TX_LOW;
          end else if (reads_left != 8'd0) begin
            if (wrote_flag) begin
              wrote_flag_next = 1'b0;
              phase_next      = PH_RS_LOW;
            end else begin
              shift_byte_next = 8'd0;
              bit_count_next  = '0;
              phase_next      = PH_RX_LOW;
            end
          end else begin
            last_status_next = ST_OK;
            phase_next       = PH_STOP_LOW;
          end
        end
      end
      PH_RX_LOW: if (over) phase_next = PH_RX_HIGH;
      PH_RX_HIGH: begin
        if (over) begin
          shift_byte_next = {shift_byte[6:0], item.sda_in};
          if (bit_inc >= BITS_PER_BYTE) begin
            bit_count_next = '0;
            rvalid         = 1'b1;
            rdata          = {shift_byte[6:0], item.sda_in};
            if (reads_left != 8'd0) reads_left_next = reads_left - 8'd1;
            phase_next     = PH_RXACK_LOW;
          end else begin
            bit_count_next = bit_inc;
            phase_next     = PH_RX_LOW;
          end
        end
      end
      PH_RXACK_LOW: if (over) phase_next = PH_RXACK_HIGH;
      PH_RXACK_HIGH: begin
        if (over) begin
          if (reads_left == 8'd0) begin
            last_status_next = ST_OK;
            phase_next       = PH_STOP_LOW;
          end else begin
            shift_byte_next = 8'd0;
            phase_next      = PH_RX_LOW;
          end
        end
      end
      PH_RS_LOW:    if (over) phase_next = PH_RS_HIGH;
      PH_RS_HIGH:   if (over) phase_next = PH_START_HOLD;
      PH_STOP_LOW:  if (over) phase_next = PH_STOP_HIGH;
      PH_STOP_HIGH: if (over) phase_next = PH_STOP_FREE;
      PH_STOP_FREE: begin
        if (over) begin
          phase_next = PH_IDLE;
          done       = 1'b1;
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = 16'd0;
      end
    endcase

    // Line drive for the coming tick follows the new phase.
    scl = 1'b1;
    sda = 1'b1;
    case (phase_next)
      PH_START_HOLD: sda = 1'b0;
      PH_TX_LOW: begin
        scl = 1'b0;
        sda = shift_byte_next[7];
      end
      PH_TX_HIGH:    sda = shift_byte_next[7];
      PH_TXACK_LOW:  scl = 1'b0;
      PH_RX_LOW:     scl = 1'b0;
      PH_RXACK_LOW: begin
        scl = 1'b0;
        sda = (reads_left_next == 8'd0);
      end
      PH_RXACK_HIGH: sda = (reads_left_next == 8'd0);
      PH_RS_LOW:     scl = 1'b0;
      PH_STOP_LOW: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      PH_STOP_HIGH:  sda = 1'b0;
      default: ;
    endcase

    result.scl_out    = scl;
    result.sda_out    = sda;
    result.byte_taken = taken;
    result.read_valid = rvalid;
    result.read_data  = rdata;
    result.busy_res   = (phase_next != PH_IDLE);
    result.done_res   = done;
    result.status     = last_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= 16'd0;
      bit_count     <= '0;
      shift_byte    <= 8'd0;
      saved_address <= 7'd0;
      writes_left   <= 8'd0;
      reads_left    <= 8'd0;
      wrote_flag    <= 1'b0;
      last_status   <= ST_OK;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      saved_address <= saved_address_next;
      writes_left   <= writes_left_next;
      reads_left    <= reads_left_next;
      wrote_flag    <= wrote_flag_next;
      last_status   <= last_status_next;
    end
  end

endmodule

@@ design/i2c_master_transfer.sv @@
// Top level of the I2C master transfer engine: configuration register,
// input/result handshake and result register around i2cm_core. Uses i2cm_pkg.
//
//  channel | signals                        | payload / meaning
//  --------+--------------------------------+---------------------------------
//  in      | in_valid, in_ready, in_data    | item_t: one bus sample tick
//  out     | out_valid, out_ready, out_data | result_t: line drive and status
//  cfg     | cfg_we, cfg_wdata              | half_period_ticks, no handshake
//
// One item per cycle: the sequencer state and the result register both load
// on the transfer edge, so a new item is taken every cycle while out_ready
// is high; the result of an accepted item is held in the result register from the cycle after.
// When out_ready drops with a result pending, in_ready drops with it.
// Reset (rst, synchronous) puts the sequencer in idle, clears the status and
// loads a half period of 250 ticks.
module i2c_master_transfer #(
  parameter int unsigned MaxTransferBytes = i2cm_pkg::MAX_TRANSFER_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2cm_pkg::item_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output i2cm_pkg::result_t out_data,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);
  import i2cm_pkg::*;

  logic [15:0] half_period;
  logic        accept;
  result_t     result;

  // Take a new item whenever the result register is empty or being drained.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_period <= cfg_wdata;
    end
  end

  i2cm_core #(
    .MaxTransferBytes(MaxTransferBytes)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .half_period (half_period),
    .item        (in_data),
    .result      (result)
  );

  // Hold the result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while still busy");

  a_take_or_read: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.byte_taken && out_data.read_valid))
    else $error("byte taken and byte read on the same tick");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != ST_UNUSED)
    else $error("status code out of range");

  a_byte_edge_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.byte_taken || out_data.read_valid) |-> !out_data.scl_out)
    else $error("byte boundary not followed by SCL low");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

endmodule
